// ----- src/scrolled_tile_background_renderer_unit_macros.svh -----
// Assertion macros for the scrolled tile background renderer.
// Depends on clk and rst_n being visible in the module that expands them.
`ifndef SCROLLED_TILE_BACKGROUND_RENDERER_UNIT_MACROS_SVH
`define SCROLLED_TILE_BACKGROUND_RENDERER_UNIT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define STBR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stbr assertion failed: same-cycle implication");

// Antecedent implies consequent in the following cycle.
`define STBR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stbr assertion failed: next-cycle implication");

`endif

// ----- src/stbr_pkg.sv -----
// Shared constants, types and the palette function for the tile background renderer.
// No dependencies; used by stbr_vram, the top level and the testbench.
`default_nettype none

package stbr_pkg;

    // Screen size in pixels.
    localparam logic [8:0] SCREEN_WIDTH  = 9'd160;
    localparam logic [8:0] SCREEN_HEIGHT = 9'd144;

    // Video memory geometry: 8 KiB held as 4 Ki words of two bytes.
    localparam int BYTE_ADDR_W = 13;
    localparam int WORD_ADDR_W = 12;
    localparam int VRAM_WORDS  = 4096;

    // Byte offset of the tile map within video memory.
    localparam logic [BYTE_ADDR_W-1:0] MAP_BASE = 13'h1800;

    // Configuration register byte addresses (word aligned).
    localparam logic [2:0] ADDR_SCROLL_X = 3'd0;
    localparam logic [2:0] ADDR_SCROLL_Y = 3'd4;

    // Operation codes of an input item.
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_RENDER = 1'b1;

    // One pending byte write into video memory.
    typedef struct packed {
        logic                   en;
        logic [BYTE_ADDR_W-1:0] addr;
        logic [7:0]             data;
    } vram_wr_t;

    // Fixed four-entry palette, lightest to darkest.
    function automatic logic [31:0] shade_color(input logic [1:0] shade);
        logic [31:0] color;
        case (shade)
            2'd0:    color = 32'hffe0f8d0;
            2'd1:    color = 32'hff88c070;
            2'd2:    color = 32'hff346856;
            2'd3:    color = 32'hff081820;
            default: color = 32'hffe0f8d0;
        endcase
        return color;
    endfunction

endpackage

`default_nettype wire

// ----- src/stbr_vram.sv -----
// Video memory: two byte banks (even and odd bytes), one write port, two read ports.
// Depends on stbr_pkg for geometry and the write struct.
`default_nettype none

module stbr_vram
(
    input  wire logic                               clk,
    input  wire stbr_pkg::vram_wr_t                 wr,
    input  wire logic [stbr_pkg::WORD_ADDR_W-1:0]   map_addr,
    input  wire logic [stbr_pkg::WORD_ADDR_W-1:0]   plane_addr,
    output logic [15:0]                             map_word,
    output logic [15:0]                             plane_word
);

    logic [7:0] bank_even [0:stbr_pkg::VRAM_WORDS-1];
    logic [7:0] bank_odd  [0:stbr_pkg::VRAM_WORDS-1];

    logic [stbr_pkg::WORD_ADDR_W-1:0] wr_word;

    assign wr_word = wr.addr[stbr_pkg::BYTE_ADDR_W-1:1];

    // Both banks: byte writes and two registered reads each, old data on a collision.
    always_ff @(posedge clk)
    begin
        if (wr.en && !wr.addr[0])
        begin
            bank_even[wr_word] <= wr.data;
        end
        if (wr.en && wr.addr[0])
        begin
            bank_odd[wr_word] <= wr.data;
        end
        map_word   <= {bank_odd[map_addr], bank_even[map_addr]};
        plane_word <= {bank_odd[plane_addr], bank_even[plane_addr]};
    end

endmodule

`default_nettype wire

// ----- src/scrolled_tile_background_renderer_unit.sv -----
// Scrolled 2bpp tile map background renderer, top level; needs stbr_pkg, stbr_vram, macros.
// A render transfer passes stage 1, stage 2, stage 3 and the output registers before its result strobes.
// Throughput: one item per cycle; busy stays low, since the pipeline never stalls.
// The two dependent video memory reads (tile map, then bit planes) set the depth.
// Reset (rst_n, async, active low) clears the scroll registers and all valid bits;
// video memory is not cleared and must be written before it is rendered from.
`default_nettype none
`include "scrolled_tile_background_renderer_unit_macros.svh"

module scrolled_tile_background_renderer_unit
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Item channel
    input  wire logic        start,
    output logic             busy,
    input  wire logic        operation,
    input  wire logic [12:0] write_address,
    input  wire logic [7:0]  write_data,
    input  wire logic [7:0]  pixel_column,
    input  wire logic [7:0]  pixel_row,
    // Result channel
    output logic             result_valid,
    output logic [7:0]       out_column,
    output logic [7:0]       out_row,
    output logic [1:0]       shade,
    output logic [31:0]      argb_color,
    // Configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // Configuration registers
    logic [7:0] scroll_x_reg, scroll_x_next;
    logic [7:0] scroll_y_reg, scroll_y_next;
    logic       cfg_write;

    // Item acceptance
    logic item_accept;
    logic render_accept;
    logic on_screen;

    // Stage 1: background coordinates
    logic       valid_s1_reg, valid_s1_next;
    logic [7:0] col_s1_reg, row_s1_reg;
    logic [7:0] bx_s1_reg, by_s1_reg;

    // Delayed byte write
    stbr_pkg::vram_wr_t wr_reg, wr_next;

    // Stage 2: tile map byte arrives
    logic       valid_s2_reg;
    logic [7:0] col_s2_reg, row_s2_reg;
    logic [2:0] fine_x_s2_reg, fine_y_s2_reg;
    logic       map_odd_s2_reg;

    // Stage 3: bit-plane bytes arrive
    logic       valid_s3_reg;
    logic [7:0] col_s3_reg, row_s3_reg;
    logic [2:0] fine_x_s3_reg;

    // Output registers
    logic        result_valid_reg;
    logic [7:0]  out_column_reg, out_row_reg;
    logic [1:0]  shade_reg, shade_next;
    logic [31:0] argb_color_reg;

    // Memory interface
    logic [stbr_pkg::BYTE_ADDR_W-1:0] map_byte_addr;
    logic [stbr_pkg::WORD_ADDR_W-1:0] map_addr;
    logic [stbr_pkg::WORD_ADDR_W-1:0] plane_addr;
    logic [15:0]                      map_word;
    logic [15:0]                      plane_word;
    logic [7:0]                       tile_num;
    logic [2:0]                       bit_sel;

    // The pipeline never holds off an item.
    assign busy          = 1'b0;
    assign item_accept   = start && !busy;
    assign on_screen     = ({1'b0, pixel_column} < stbr_pkg::SCREEN_WIDTH)
                        && ({1'b0, pixel_row} < stbr_pkg::SCREEN_HEIGHT);
    assign render_accept = item_accept && (operation == stbr_pkg::OP_RENDER) && on_screen;

    // Configuration writes; the low two address bits are ignored.
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_comb
    begin
        scroll_x_next = scroll_x_reg;
        scroll_y_next = scroll_y_reg;
        if (cfg_write)
        begin
            case (paddr & 3'b100)
                stbr_pkg::ADDR_SCROLL_X: scroll_x_next = pwdata[7:0];
                stbr_pkg::ADDR_SCROLL_Y: scroll_y_next = pwdata[7:0];
                default:                 scroll_x_next = scroll_x_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr & 3'b100)
            stbr_pkg::ADDR_SCROLL_X: prdata = {24'd0, scroll_x_reg};
            stbr_pkg::ADDR_SCROLL_Y: prdata = {24'd0, scroll_y_reg};
            default:                 prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scroll_x_reg <= 8'd0;
            scroll_y_reg <= 8'd0;
        end
        else
        begin
            scroll_x_reg <= scroll_x_next;
            scroll_y_reg <= scroll_y_next;
        end
    end

    // A write is performed in the cycle after its transfer, so a render accepted just
    // before it still reads old plane data and a render just after it sees the byte.
    always_comb
    begin
        wr_next.en   = item_accept && (operation == stbr_pkg::OP_WRITE);
        wr_next.addr = write_address;
        wr_next.data = write_data;
    end

    assign valid_s1_next = render_accept;

    // Valid bits of every stage, and the delayed byte write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg           <= '0;
            valid_s1_reg     <= 1'b0;
            valid_s2_reg     <= 1'b0;
            valid_s3_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            wr_reg           <= wr_next;
            valid_s1_reg     <= valid_s1_next;
            valid_s2_reg     <= valid_s1_reg;
            valid_s3_reg     <= valid_s2_reg;
            result_valid_reg <= valid_s3_reg;
        end
    end

    // Stage 1 payload: scrolled position on the 256x256 background.
    always_ff @(posedge clk)
    begin
        col_s1_reg  <= pixel_column;
        row_s1_reg  <= pixel_row;
        bx_s1_reg   <= scroll_x_reg + pixel_column;
        by_s1_reg   <= scroll_y_reg + pixel_row;
    end

    // Tile map lookup address: 32 entries per row of tiles.
    assign map_byte_addr = stbr_pkg::MAP_BASE
                         + {3'b000, by_s1_reg[7:3], bx_s1_reg[7:3]};
    assign map_addr      = map_byte_addr[stbr_pkg::BYTE_ADDR_W-1:1];

    // Stage 2 payload.
    always_ff @(posedge clk)
    begin
        col_s2_reg     <= col_s1_reg;
        row_s2_reg     <= row_s1_reg;
        fine_x_s2_reg  <= bx_s1_reg[2:0];
        fine_y_s2_reg  <= by_s1_reg[2:0];
        map_odd_s2_reg <= map_byte_addr[0];
    end

    // Tile number picks its plane pair: 16 bytes per tile, 2 per line.
    assign tile_num   = map_odd_s2_reg ? map_word[15:8] : map_word[7:0];
    assign plane_addr = {1'b0, tile_num, fine_y_s2_reg};

    // Stage 3 payload.
    always_ff @(posedge clk)
    begin
        col_s3_reg    <= col_s2_reg;
        row_s3_reg    <= row_s2_reg;
        fine_x_s3_reg <= fine_x_s2_reg;
    end

    // Leftmost pixel is bit 7; the first plane byte gives the high shade bit.
    assign bit_sel    = ~fine_x_s3_reg;
    assign shade_next = {plane_word[bit_sel], plane_word[{1'b1, bit_sel}]};

    always_ff @(posedge clk)
    begin
        out_column_reg <= col_s3_reg;
        out_row_reg    <= row_s3_reg;
        shade_reg      <= shade_next;
        argb_color_reg <= stbr_pkg::shade_color(shade_next);
    end

    assign result_valid = result_valid_reg;
    assign out_column   = out_column_reg;
    assign out_row      = out_row_reg;
    assign shade        = shade_reg;
    assign argb_color   = argb_color_reg;

    // Video memory.
    stbr_vram u_vram
    (
        .clk        (clk),
        .wr         (wr_reg),
        .map_addr   (map_addr),
        .plane_addr (plane_addr),
        .map_word   (map_word),
        .plane_word (plane_word)
    );

    // A result carries an on-screen position.
    `STBR_ASSERT_NOW(a_result_on_screen, result_valid, ({1'b0, out_column} < stbr_pkg::SCREEN_WIDTH) && ({1'b0, out_row} < stbr_pkg::SCREEN_HEIGHT))
    // Every result comes from an earlier render request on the item channel.
    `STBR_ASSERT_NOW(a_result_has_source, result_valid, $past(start && operation, 4))
    // A write transfer starts no render and schedules a memory write.
    `STBR_ASSERT_NEXT(a_write_no_render, start && !busy && !operation, wr_reg.en && !valid_s1_reg)

endmodule

`default_nettype wire

// ----- test/scrolled_tile_background_renderer_unit_tb.sv -----
// Self-checking testbench for the scrolled tile background renderer.
// Depends on stbr_pkg and the scrolled_tile_background_renderer_unit top level.
// Directed rows come first, then random write and render sequences under several scroll settings.
`timescale 1ns / 1ps

module scrolled_tile_background_renderer_unit_tb;

    // One input item as driven on the item channel.
    typedef struct packed {
        logic        op;
        logic [12:0] addr;
        logic [7:0]  data;
        logic [7:0]  col;
        logic [7:0]  row;
    } pixel_item_t;

    // One rendered pixel as seen on the result channel.
    typedef struct packed {
        logic [7:0]  col;
        logic [7:0]  row;
        logic [1:0]  shade;
        logic [31:0] color;
    } pixel_result_t;

    // One row of the directed stimulus, optionally with its result typed in.
    typedef struct packed {
        pixel_item_t   item;
        logic          typed;
        logic [1:0]    shade;
        logic [31:0]   color;
    } directed_row_t;

    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS  = 72;
    localparam int NUM_PHASES   = 6;
    localparam logic [12:0] TILE_MAP_BASE = 13'd6144;

    // Palette, shade 0 in the low word.
    localparam logic [127:0] PALETTE = {32'hff081820, 32'hff346856, 32'hff88c070, 32'hffe0f8d0};

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        operation;
    logic [12:0] write_address;
    logic [7:0]  write_data;
    logic [7:0]  pixel_column;
    logic [7:0]  pixel_row;
    logic        result_valid;
    logic [7:0]  out_column;
    logic [7:0]  out_row;
    logic [1:0]  shade;
    logic [31:0] argb_color;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Local copy of the video memory, the bytes written so far and the scroll registers.
    logic [7:0]      vram_model [0:8191];
    bit              vram_written [0:8191];
    logic [7:0]      scroll_x_q;
    logic [7:0]      scroll_y_q;

    pixel_result_t   pending_pixels [$];
    directed_row_t   directed_rows [$];
    pixel_result_t   result_want;
    int              error_count;
    int              items_sent;
    int              burst_left;

    scrolled_tile_background_renderer_unit DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .operation     (operation),
        .write_address (write_address),
        .write_data    (write_data),
        .pixel_column  (pixel_column),
        .pixel_row     (pixel_row),
        .result_valid  (result_valid),
        .out_column    (out_column),
        .out_row       (out_row),
        .shade         (shade),
        .argb_color    (argb_color),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #2_000_000;
        $display("[scrolled_tile_background_renderer_unit] ERROR");
        $finish;
    end

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        error_count++;
    endtask

    // Byte address of the tile map entry that covers a screen pixel.
    function automatic logic [12:0] map_entry_addr(input logic [7:0] col, input logic [7:0] row);
        logic [7:0] bx;
        logic [7:0] by;
        bx = col + scroll_x_q;
        by = row + scroll_y_q;
        return TILE_MAP_BASE + {3'b000, by[7:3], bx[7:3]};
    endfunction

    // Byte address of the first bit-plane byte of the tile row under a screen line.
    function automatic logic [12:0] plane_row_addr(input logic [7:0] tile, input logic [7:0] row);
        logic [7:0] by;
        by = row + scroll_y_q;
        return {1'b0, tile, by[2:0], 1'b0};
    endfunction

    // Shade and color that a render of an on-screen pixel produces.
    function automatic pixel_result_t render_expected(input logic [7:0] col,
                                                      input logic [7:0] row);
        logic [7:0]    bx;
        logic [12:0]   row_addr;
        logic [7:0]    plane_hi;
        logic [7:0]    plane_lo;
        int            bitpos;
        pixel_result_t r;
        bx       = col + scroll_x_q;
        row_addr = plane_row_addr(vram_model[map_entry_addr(col, row)], row);
        plane_hi = vram_model[row_addr];
        plane_lo = vram_model[{row_addr[12:1], 1'b1}];
        bitpos   = 7 - bx[2:0];
        r.col    = col;
        r.row    = row;
        r.shade  = {plane_hi[bitpos], plane_lo[bitpos]};
        r.color  = PALETTE[r.shade * 32 +: 32];
        return r;
    endfunction

    // Drives one item, waits for its transfer and records what it should cause.
    task automatic send_item(input pixel_item_t it, input logic typed,
                             input logic [1:0] typed_shade, input logic [31:0] typed_color);
        int            gap;
        pixel_result_t want;
        if (burst_left > 0)
        begin
            gap = 0;
            burst_left--;
        end
        else
        begin
            gap = $urandom_range(0, 8);
            if ($urandom_range(0, 15) == 0)
                burst_left = $urandom_range(10, 30);
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start         <= 1'b1;
        operation     <= it.op;
        write_address <= it.addr;
        write_data    <= it.data;
        pixel_column  <= it.col;
        pixel_row     <= it.row;
        do @(posedge clk); while (busy);
        items_sent++;
        if (it.op == stbr_pkg::OP_WRITE)
        begin
            vram_model[it.addr]   = it.data;
            vram_written[it.addr] = 1'b1;
        end
        else if ({1'b0, it.col} < stbr_pkg::SCREEN_WIDTH
                 && {1'b0, it.row} < stbr_pkg::SCREEN_HEIGHT)
        begin
            if (typed)
            begin
                want.col   = it.col;
                want.row   = it.row;
                want.shade = typed_shade;
                want.color = typed_color;
            end
            else
                want = render_expected(it.col, it.row);
            pending_pixels.push_back(want);
        end
    endtask

    // Random write item, with random pixel fields that the block must ignore.
    task automatic send_write(input logic [12:0] addr, input logic [7:0] data);
        pixel_item_t it;
        it.op   = stbr_pkg::OP_WRITE;
        it.addr = addr;
        it.data = data;
        it.col  = 8'($urandom_range(0, 255));
        it.row  = 8'($urandom_range(0, 255));
        send_item(it, 1'b0, 2'd0, 32'd0);
    endtask

    // Random render item, with random write fields that the block must ignore.
    task automatic send_render(input logic [7:0] col, input logic [7:0] row);
        pixel_item_t it;
        it.op   = stbr_pkg::OP_RENDER;
        it.addr = 13'($urandom_range(0, 8191));
        it.data = 8'($urandom_range(0, 255));
        it.col  = col;
        it.row  = row;
        send_item(it, 1'b0, 2'd0, 32'd0);
    endtask

    // Renders a random on-screen pixel, first writing any byte it reads that is still unwritten.
    task automatic render_sequence;
        logic [7:0]  col;
        logic [7:0]  row;
        logic [12:0] map_addr;
        logic [12:0] row_addr;
        col      = 8'($urandom_range(0, 159));
        row      = 8'($urandom_range(0, 143));
        map_addr = map_entry_addr(col, row);
        if (!vram_written[map_addr] || $urandom_range(0, 3) == 0)
            send_write(map_addr, 8'($urandom_range(0, 255)));
        row_addr = plane_row_addr(vram_model[map_addr], row);
        if (!vram_written[row_addr] || $urandom_range(0, 3) == 0)
            send_write(row_addr, 8'($urandom_range(0, 255)));
        if (!vram_written[{row_addr[12:1], 1'b1}] || $urandom_range(0, 3) == 0)
            send_write({row_addr[12:1], 1'b1}, 8'($urandom_range(0, 255)));
        send_render(col, row);
    endtask

    // Stops sending and waits until every expected pixel has come out.
    task automatic wait_idle;
        start <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Register write transfer: setup cycle, then access cycle.
    task automatic write_register(input logic [2:0] addr, input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {24'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == stbr_pkg::ADDR_SCROLL_X)
            scroll_x_q = value;
        else if (addr == stbr_pkg::ADDR_SCROLL_Y)
            scroll_y_q = value;
        @(posedge clk);
    endtask

    // Register read transfer; the data is taken at the edge that ends the access cycle.
    task automatic check_register(input logic [2:0] addr, input logic [7:0] want);
        logic [31:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got[7:0] !== want)
            report_mismatch("scroll register readback", {24'd0, got[7:0]}, {24'd0, want});
        @(posedge clk);
    endtask

    // Adds one row to the directed stimulus.
    task automatic add_row(input logic op, input logic [12:0] addr, input logic [7:0] data,
                           input logic [7:0] col, input logic [7:0] row, input logic typed,
                           input logic [1:0] sh, input logic [31:0] color);
        directed_row_t r;
        r.item.op   = op;
        r.item.addr = addr;
        r.item.data = data;
        r.item.col  = col;
        r.item.row  = row;
        r.typed     = typed;
        r.shade     = sh;
        r.color     = color;
        directed_rows.push_back(r);
    endtask

    // Each strobed result is matched against the oldest expected pixel.
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (pending_pixels.size() == 0)
                report_mismatch("unexpected result, column", {24'd0, out_column}, 32'd0);
            else
            begin
                result_want = pending_pixels.pop_front();
                if (out_column !== result_want.col)
                    report_mismatch("out_column", {24'd0, out_column}, {24'd0, result_want.col});
                if (out_row !== result_want.row)
                    report_mismatch("out_row", {24'd0, out_row}, {24'd0, result_want.row});
                if (shade !== result_want.shade)
                    report_mismatch("shade", {30'd0, shade}, {30'd0, result_want.shade});
                if (argb_color !== result_want.color)
                    report_mismatch("argb_color", argb_color, result_want.color);
            end
        end
    end

    // Main sequence: reset, directed rows, then random phases under changing scroll.
    initial
    begin
        int          choice;
        logic [7:0]  sx;
        logic [7:0]  sy;
        logic [7:0]  col;
        int          phase_start;

        rst_n         <= 1'b0;
        start         <= 1'b0;
        operation     <= stbr_pkg::OP_WRITE;
        write_address <= 13'd0;
        write_data    <= 8'd0;
        pixel_column  <= 8'd0;
        pixel_row     <= 8'd0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= 3'd0;
        pwdata        <= 32'd0;
        scroll_x_q    = 8'd0;
        scroll_y_q    = 8'd0;
        error_count   = 0;
        items_sent    = 0;
        burst_left    = 0;
        foreach (vram_written[i])
            vram_written[i] = 1'b0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Scroll registers read back as zero after reset.
        check_register(stbr_pkg::ADDR_SCROLL_X, 8'd0);
        check_register(stbr_pkg::ADDR_SCROLL_Y, 8'd0);

        // Tile 0 in the top left map entry, its first row exercised in every shade.
        add_row(stbr_pkg::OP_WRITE,  13'd6144, 8'h00, 8'd159, 8'd143, 1'b0, 2'd0, 32'd0);
        add_row(stbr_pkg::OP_WRITE,  13'd0,    8'hff, 8'd0,   8'd0,   1'b0, 2'd0, 32'd0);
        add_row(stbr_pkg::OP_WRITE,  13'd1,    8'h00, 8'd255, 8'd255, 1'b0, 2'd0, 32'd0);
        add_row(stbr_pkg::OP_RENDER, 13'd0,    8'h00, 8'd0,   8'd0,   1'b1, 2'd2, 32'hff346856);
        add_row(stbr_pkg::OP_WRITE,  13'd1,    8'hff, 8'd0,   8'd0,   1'b0, 2'd0, 32'd0);
        add_row(stbr_pkg::OP_RENDER, 13'd8191, 8'hff, 8'd7,   8'd0,   1'b1, 2'd3, 32'hff081820);
        add_row(stbr_pkg::OP_WRITE,  13'd0,    8'h00, 8'd0,   8'd0,   1'b0, 2'd0, 32'd0);
        add_row(stbr_pkg::OP_RENDER, 13'd0,    8'h00, 8'd3,   8'd0,   1'b1, 2'd1, 32'hff88c070);
        add_row(stbr_pkg::OP_WRITE,  13'd1,    8'h00, 8'd0,   8'd0,   1'b0, 2'd0, 32'd0);
        add_row(stbr_pkg::OP_RENDER, 13'd0,    8'h00, 8'd0,   8'd0,   1'b1, 2'd0, 32'hffe0f8d0);
        // Pixels off the screen give no result.
        add_row(stbr_pkg::OP_RENDER, 13'd0,    8'h00, 8'd160, 8'd0,   1'b0, 2'd0, 32'd0);
        add_row(stbr_pkg::OP_RENDER, 13'd0,    8'h00, 8'd0,   8'd144, 1'b0, 2'd0, 32'd0);
        add_row(stbr_pkg::OP_RENDER, 13'd0,    8'h00, 8'd255, 8'd255, 1'b0, 2'd0, 32'd0);
        // Top address, then the bottom right pixel through tile 255 at the top of tile data.
        add_row(stbr_pkg::OP_WRITE,  13'd8191, 8'hff, 8'd0,   8'd0,   1'b0, 2'd0, 32'd0);
        add_row(stbr_pkg::OP_WRITE,  13'd6707, 8'hff, 8'd0,   8'd0,   1'b0, 2'd0, 32'd0);
        add_row(stbr_pkg::OP_WRITE,  13'd4094, 8'ha5, 8'd0,   8'd0,   1'b0, 2'd0, 32'd0);
        add_row(stbr_pkg::OP_WRITE,  13'd4095, 8'h5a, 8'd0,   8'd0,   1'b0, 2'd0, 32'd0);
        add_row(stbr_pkg::OP_RENDER, 13'd0,    8'h00, 8'd159, 8'd143, 1'b1, 2'd2, 32'hff346856);
        add_row(stbr_pkg::OP_RENDER, 13'd0,    8'h00, 8'd1,   8'd0,   1'b1, 2'd0, 32'hffe0f8d0);

        foreach (directed_rows[i])
            send_item(directed_rows[i].item, directed_rows[i].typed,
                      directed_rows[i].shade, directed_rows[i].color);

        // Random phases; the scroll registers change only while the block is idle.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_idle();
            case (p)
                0: begin sx = 8'd255; sy = 8'd255; end
                1: begin sx = 8'd0;   sy = 8'd255; end
                2: begin sx = 8'd255; sy = 8'd0;   end
                default:
                begin
                    sx = 8'($urandom_range(0, 255));
                    sy = 8'($urandom_range(0, 255));
                end
            endcase
            write_register(stbr_pkg::ADDR_SCROLL_X, sx);
            write_register(stbr_pkg::ADDR_SCROLL_Y, sy);
            check_register(stbr_pkg::ADDR_SCROLL_X, sx);
            check_register(stbr_pkg::ADDR_SCROLL_Y, sy);

            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
            begin
                choice = $urandom_range(0, 9);
                if (choice <= 6)
                    render_sequence();
                else if (choice <= 8)
                    send_write(13'($urandom_range(0, 8191)), 8'($urandom_range(0, 255)));
                else
                begin
                    col = 8'($urandom_range(0, 255));
                    if (col < 8'd160)
                        send_render(col, 8'($urandom_range(144, 255)));
                    else
                        send_render(col, 8'($urandom_range(0, 255)));
                end
                // Now and then hold off until the pipeline has emptied.
                if ($urandom_range(0, 39) == 0)
                    wait_idle();
            end
        end

        wait_idle();
        if (error_count == 0)
            $display("[scrolled_tile_background_renderer_unit] OK");
        else
            $display("[scrolled_tile_background_renderer_unit] ERROR");
        $finish;
    end

endmodule
